>>> src/voxel_face_classifier_unit_assert.svh
// Assertion macros shared by the voxel face classifier modules.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef VOXEL_FACE_CLASSIFIER_UNIT_ASSERT_SVH
`define VOXEL_FACE_CLASSIFIER_UNIT_ASSERT_SVH

// A property that must hold at every clock edge out of reset.
`define VFC_CHECK(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A condition that must be followed by a consequence at the next edge.
`define VFC_CHECK_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/vfc_pkg.sv
// Shared types and constants of the voxel face classifier.
// No dependencies; used by every module of the block.
package vfc_pkg;

    localparam int COORD_W     = 8;
    localparam int SIZE_W      = 9;
    localparam int TALLY_W     = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int PLANE_AW    = 2 * COORD_W;
    localparam int PLANE_DEPTH = 1 << PLANE_AW;
    localparam int LINE_DEPTH  = 1 << COORD_W;

    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;
    localparam logic [SIZE_W-1:0] SIZE_MIN   = 9'd3;

    typedef enum logic [1:0] {
        CLASS_EMPTY      = 2'd0,
        CLASS_SOLID      = 2'd1,
        CLASS_VERTICAL   = 2'd2,
        CLASS_HORIZONTAL = 2'd3
    } vfc_class_t;

    typedef struct packed {
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] pos_z;
        vfc_class_t         voxel_class;
        logic [TALLY_W-1:0] vertical_count;
        logic               last;
    } vfc_result_t;

    typedef struct packed {
        logic        valid;
        vfc_result_t data;
    } vfc_push_t;

    // Last coordinate of an axis for a programmed size, clamped to 3..256.
    function automatic logic [COORD_W-1:0] last_coord(input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] dec;
        dec = size - 9'd1;
        if (size < SIZE_MIN)
            return 8'd2;
        else if (size > SIZE_RESET)
            return '1;
        else
            return dec[COORD_W-1:0];
    endfunction

endpackage

>>> src/vfc_front.sv
// Front part: raster cursors, plane and line stores, 3x3x3 window and classifier.
// Depends on vfc_pkg and the assertion macro header.
module vfc_front
    import vfc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,
    input  logic                 voxel_valid,
    output logic                 voxel_stall,
    input  logic                 occupied,
    input  logic [LEVEL_W-1:0]   queue_level,
    output vfc_push_t            push
);

    logic [SIZE_W-1:0]  size_x_reg, size_y_reg, size_z_reg;
    logic [COORD_W-1:0] cur_x_reg, cur_y_reg, cur_z_reg;
    logic [COORD_W-1:0] cur_x_next, cur_y_next, cur_z_next;
    logic [COORD_W-1:0] lim_x, lim_y, lim_z;
    logic               accept;
    logic               cfg_hit;

    logic               s1_valid_reg;
    logic               s1_occ_reg;
    logic               s1_emit_reg;
    logic               s1_last_reg;
    logic               s1_bottom_reg;
    logic [COORD_W-1:0] s1_y_reg, s1_z_reg;
    logic [COORD_W-1:0] s1_px_reg, s1_py_reg, s1_pz_reg;

    logic [1:0]         plane_mem [PLANE_DEPTH];
    logic [5:0]         line_mem  [LINE_DEPTH];
    logic [1:0]         plane_rd_reg;
    logic [5:0]         line_rd_reg;
    logic [5:0]         line_wr;

    logic [17:0]        window_reg;
    logic [8:0]         col, win1, win2;
    vfc_class_t         cls;
    logic [TALLY_W-1:0] tally_reg, tally_next;
    logic [LEVEL_W:0]   committed;

    assign lim_x = last_coord(size_x_reg);
    assign lim_y = last_coord(size_y_reg);
    assign lim_z = last_coord(size_z_reg);

    // Items in stage one land in the queue when they emit, so count them all as taken.
    assign committed   = {1'b0, queue_level} + {{LEVEL_W{1'b0}}, s1_valid_reg};
    assign voxel_stall = committed > (LEVEL_W+1)'(QUEUE_DEPTH - 1);
    assign accept      = voxel_valid && !voxel_stall;
    assign cfg_hit     = cfg_write && (cfg_index == CFG_SIZE_X || cfg_index == CFG_SIZE_Y
                                       || cfg_index == CFG_SIZE_Z);

    always_comb
    begin
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        cur_z_next = cur_z_reg + 8'd1;
        if (cur_z_reg == lim_z)
        begin
            cur_z_next = '0;
            cur_y_next = cur_y_reg + 8'd1;
            if (cur_y_reg == lim_y)
            begin
                cur_y_next = '0;
                cur_x_next = cur_x_reg + 8'd1;
                if (cur_x_reg == lim_x)
                begin
                    cur_x_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg   <= SIZE_RESET;
            size_y_reg   <= SIZE_RESET;
            size_z_reg   <= SIZE_RESET;
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
            cur_z_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (cfg_hit)
            begin
                cur_x_reg <= '0;
                cur_y_reg <= '0;
                cur_z_reg <= '0;
                case (cfg_index)
                    CFG_SIZE_X: size_x_reg <= cfg_data;
                    CFG_SIZE_Y: size_y_reg <= cfg_data;
                    CFG_SIZE_Z: size_z_reg <= cfg_data;
                    default:    size_x_reg <= size_x_reg;
                endcase
            end
            else if (accept)
            begin
                cur_x_reg <= cur_x_next;
                cur_y_reg <= cur_y_next;
                cur_z_reg <= cur_z_next;
            end
        end
    end

    // Stage one payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_occ_reg    <= occupied;
            s1_emit_reg   <= (cur_x_reg >= 8'd2) && (cur_y_reg >= 8'd2) && (cur_z_reg >= 8'd2);
            s1_last_reg   <= (cur_x_reg == lim_x) && (cur_y_reg == lim_y)
                             && (cur_z_reg == lim_z);
            s1_bottom_reg <= cur_z_reg == 8'd2;
            s1_y_reg      <= cur_y_reg;
            s1_z_reg      <= cur_z_reg;
            s1_px_reg     <= cur_x_reg - 8'd1;
            s1_py_reg     <= cur_y_reg - 8'd1;
            s1_pz_reg     <= cur_z_reg - 8'd1;
        end
    end

    // Column of nine cells at the arriving height: bit 3*dx+dy, where dx and dy
    // count back from the arriving plane and line.
    assign col = {line_rd_reg[5], line_rd_reg[4], plane_rd_reg[1],
                  line_rd_reg[3], line_rd_reg[2], plane_rd_reg[0],
                  line_rd_reg[1], line_rd_reg[0], s1_occ_reg};

    // Each line entry shifts its two older lines by one.
    assign line_wr = {col[7], col[6], col[4], col[3], col[1], col[0]};

    // Reads at acceptance, write-back in the next cycle; an address recurs only
    // a full line or plane later, so the two never collide.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            plane_rd_reg <= plane_mem[{cur_y_reg, cur_z_reg}];
            line_rd_reg  <= line_mem[cur_z_reg];
        end
        if (s1_valid_reg)
        begin
            plane_mem[{s1_y_reg, s1_z_reg}] <= {plane_rd_reg[0], s1_occ_reg};
            line_mem[s1_z_reg]              <= line_wr;
        end
    end

    assign win1 = window_reg[8:0];
    assign win2 = window_reg[17:9];

    always_comb
    begin
        if (!win1[4])
            cls = CLASS_EMPTY;
        else if (s1_bottom_reg)
            cls = CLASS_HORIZONTAL;
        else if (&{col, win1, win2})
            cls = CLASS_SOLID;
        else if (!(&win1))
            cls = CLASS_VERTICAL;
        else
            cls = CLASS_HORIZONTAL;
    end

    always_comb
    begin
        tally_next = tally_reg;
        if (s1_valid_reg && s1_emit_reg && cls == CLASS_VERTICAL && tally_reg != TALLY_MAX)
            tally_next = tally_reg + 24'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            tally_reg  <= '0;
        end
        else
        begin
            if (s1_valid_reg)
                window_reg <= {win1, col};
            if (cfg_hit || (s1_valid_reg && s1_last_reg))
                tally_reg <= '0;
            else
                tally_reg <= tally_next;
        end
    end

    assign push.valid               = s1_valid_reg && s1_emit_reg;
    assign push.data.pos_x          = s1_px_reg;
    assign push.data.pos_y          = s1_py_reg;
    assign push.data.pos_z          = s1_pz_reg;
    assign push.data.voxel_class    = cls;
    assign push.data.vertical_count = tally_next;
    assign push.data.last           = s1_last_reg;

`include "voxel_face_classifier_unit_assert.svh"

    `VFC_CHECK(a_last_is_emitted, !(s1_valid_reg && s1_last_reg) || s1_emit_reg, "grid end without result")
    `VFC_CHECK(a_push_has_room, !push.valid || queue_level < LEVEL_W'(QUEUE_DEPTH), "push into full queue")
    `VFC_CHECK_NEXT(a_tally_restart, s1_valid_reg && s1_last_reg, tally_reg == '0, "tally kept past grid end")

endmodule

>>> src/vfc_queue.sv
// Back part: short result queue that drives the output channel.
// Depends on vfc_pkg and the assertion macro header.
module vfc_queue
    import vfc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  vfc_push_t          push,
    output logic [LEVEL_W-1:0] level,
    output logic               result_valid,
    input  logic               result_stall,
    output vfc_result_t        result
);

    vfc_result_t        entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   head_reg, tail_reg;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic               pop;

    assign result_valid = level_reg != '0;
    assign pop          = result_valid && !result_stall;
    assign result       = entries_reg[head_reg];
    assign level        = level_reg;

    always_comb
    begin
        level_next = level_reg;
        if (push.valid && !pop)
            level_next = level_reg + LEVEL_W'(1);
        else if (!push.valid && pop)
            level_next = level_reg - LEVEL_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            level_reg <= '0;
        end
        else
        begin
            level_reg <= level_next;
            if (push.valid)
                tail_reg <= tail_reg + PTR_W'(1);
            if (pop)
                head_reg <= head_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            entries_reg[tail_reg] <= push.data;
    end

`include "voxel_face_classifier_unit_assert.svh"

    `VFC_CHECK(a_level_bound, level_reg <= LEVEL_W'(QUEUE_DEPTH), "queue level out of range")
    `VFC_CHECK_NEXT(a_pop_drains, pop && !push.valid, level_reg == $past(level_reg) - LEVEL_W'(1), "pop lost")
    `VFC_CHECK_NEXT(a_hold, result_valid && result_stall, result_valid && $stable(result), "stalled beat changed")

endmodule

>>> src/voxel_face_classifier_unit.sv
// Top level of the voxel face classifier: front classifier plus result queue.
// Depends on vfc_pkg, vfc_front and vfc_queue.
//
// Usage: occupancy bits enter one beat at a time on the voxel channel
// (voxel_valid, voxel_stall, occupied) in raster order, height fastest, then
// y, then x. For every voxel at least two steps in from the low corner on all
// three axes, one result beat leaves on the result channel (result_valid,
// result_stall) carrying the coordinates of the voxel one step back on each
// axis, its class, the saturating running count of vertical faces in this
// grid, and last on the grid's final interior voxel.
// Throughput is one voxel per cycle while voxel_stall is low. A beat taken
// is registered with its plane-store and line-store reads, classified in the
// next cycle and written into the four-entry queue at the end of that cycle;
// its result is then valid once the results ahead of it have been taken.
// The plane store is read once and written once per voxel.
// When the receiver stalls, the queue fills and the voxel channel stalls once
// the queue plus the item being classified reach its depth; nothing is lost.
// Reset clears the cursors, the counter and the queue and sets all three sizes
// to 256; no store clearing is needed, so voxels are taken right after reset.
// A write to any size register restarts the grid at the origin.
module voxel_face_classifier_unit
    import vfc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0]    cfg_data,
    input  logic                 voxel_valid,
    output logic                 voxel_stall,
    input  logic                 occupied,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [COORD_W-1:0]   pos_x,
    output logic [COORD_W-1:0]   pos_y,
    output logic [COORD_W-1:0]   pos_z,
    output logic [1:0]           voxel_class,
    output logic [TALLY_W-1:0]   vertical_count,
    output logic                 last
);

    vfc_push_t          push;
    logic [LEVEL_W-1:0] queue_level;
    vfc_result_t        result;

    // Front: cursors, stores, window and classification.
    vfc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .voxel_valid (voxel_valid),
        .voxel_stall (voxel_stall),
        .occupied    (occupied),
        .queue_level (queue_level),
        .push        (push)
    );

    // Back: the queue decouples classification from the receiver.
    vfc_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .level        (queue_level),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    assign pos_x          = result.pos_x;
    assign pos_y          = result.pos_y;
    assign pos_z          = result.pos_z;
    assign voxel_class    = result.voxel_class;
    assign vertical_count = result.vertical_count;
    assign last           = result.last;

endmodule
